/* design/timed_input_debouncer_top_macros.svh */
// Assertion macros shared by the debouncer's checker.
`ifndef TIMED_INPUT_DEBOUNCER_TOP_MACROS_SVH
`define TIMED_INPUT_DEBOUNCER_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define TID_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("debouncer check failed in the same cycle");

// Next-cycle implication, ignored while reset is high.
`define TID_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("debouncer check failed in the following cycle");

`endif

/* design/tid_pkg.sv */
package tid_pkg;

   // Width of timestamps and durations; all time arithmetic wraps at this width.
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam int MODE_W     = 2;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(10);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 1'b1;

   // Debounce policies. The unused code behaves as stable wait.
   typedef enum logic [MODE_W-1:0] {
      MODE_STABLE  = 2'd0,
      MODE_LOCKOUT = 2'd1,
      MODE_PROMPT  = 2'd2
   } debounce_mode_type;

   typedef struct packed {
      logic [INTERVAL_W-1:0] interval_ms;
      logic [MODE_W-1:0]     debounce_mode;
   } tid_cfg_type;

   typedef struct packed {
      logic              mode;
      logic              sample_level;
      logic [TIME_W-1:0] now_ms;
   } req_item_type;

   typedef struct packed {
      logic              debounced_level;
      logic              changed;
      logic              rose;
      logic              fell;
      logic [TIME_W-1:0] previous_duration;
      logic [TIME_W-1:0] current_duration;
   } rsp_item_type;

endpackage

/* design/tid_core.sv */
module tid_core
   import tid_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  tid_cfg_type  cfg,
   input  logic         upd_en,
   input  req_item_type item,
   output rsp_item_type result
);

   logic              stable_ff, stable_in;
   logic              unstable_ff, unstable_in;
   logic [TIME_W-1:0] event_ff, event_in;
   logic [TIME_W-1:0] change_ff, change_in;
   logic [TIME_W-1:0] prior_ff, prior_in;

   logic [TIME_W-1:0] since_event;
   logic [TIME_W-1:0] since_change;
   logic              settled;
   logic              diff_stable;
   logic              diff_unstable;
   logic              accept;

   assign since_event   = item.now_ms - event_ff;
   assign since_change  = item.now_ms - change_ff;
   assign settled       = since_event >= {{(TIME_W-INTERVAL_W){1'b0}}, cfg.interval_ms};
   assign diff_stable   = item.sample_level != stable_ff;
   assign diff_unstable = item.sample_level != unstable_ff;

   always_comb begin
      stable_in   = stable_ff;
      unstable_in = unstable_ff;
      event_in    = event_ff;
      change_in   = change_ff;
      prior_in    = prior_ff;
      accept      = 1'b0;

      if (item.mode) begin
         stable_in   = item.sample_level;
         unstable_in = item.sample_level;
         event_in    = (cfg.debounce_mode == MODE_LOCKOUT) ? '0 : item.now_ms;
      end else begin
         unique case (cfg.debounce_mode)
            MODE_LOCKOUT: begin
               if (settled && diff_stable) begin
                  event_in = item.now_ms;
                  accept   = 1'b1;
               end
            end
            MODE_PROMPT: begin
               // The level change and the unstable timer restart are independent.
               if (settled && diff_stable) begin
                  accept = 1'b1;
               end
               if (diff_unstable) begin
                  unstable_in = ~unstable_ff;
                  event_in    = item.now_ms;
               end
            end
            default: begin
               if (diff_unstable) begin
                  unstable_in = ~unstable_ff;
                  event_in    = item.now_ms;
               end else if (settled && diff_stable) begin
                  event_in = item.now_ms;
                  accept   = 1'b1;
               end
            end
         endcase
      end

      if (accept) begin
         stable_in = ~stable_ff;
         prior_in  = since_change;
         change_in = item.now_ms;
      end
   end

   always_comb begin
      result.debounced_level   = stable_in;
      result.changed           = accept;
      result.rose              = accept && stable_in;
      result.fell              = accept && !stable_in;
      result.previous_duration = prior_in;
      // A change restarts the current state at this very timestamp.
      result.current_duration  = accept ? '0 : since_change;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff   <= 1'b0;
         unstable_ff <= 1'b0;
         event_ff    <= '0;
         change_ff   <= '0;
         prior_ff    <= '0;
      end else if (upd_en) begin
         stable_ff   <= stable_in;
         unstable_ff <= unstable_in;
         event_ff    <= event_in;
         change_ff   <= change_in;
         prior_ff    <= prior_in;
      end
   end

endmodule

/* design/timed_input_debouncer_top.sv */
// Timed input debouncer. Each request beat carries a raw input level and a
// wrapping 32-bit millisecond timestamp; mode high restarts the debouncer at
// that level, mode low feeds it a sample. Every request produces exactly one
// response beat with the debounced level, a changed pulse with rose and fell
// flags, how long the previous debounced state lasted and how long the
// current one has lasted. The policy comes from the debounce_mode register
// (stable wait, lock-out or prompt detection; the unused code acts as stable
// wait) and the settle time from interval_ms. The block takes one beat per
// clock cycle while the response side is not stalled. A request is held in
// the input register, and its response is then registered in the response
// register. A stalled response holds the input register, and the request
// side stalls in that same cycle. The whole state update for a sample is
// combinational between those registers, which is what sets that
// throughput. Write the registers only while no beat is in flight.
module timed_input_debouncer_top
   import tid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_data,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_data,

   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   tid_cfg_type  cfg_ff;

   // Input register stage.
   logic         in_valid_ff, in_valid_in;
   req_item_type in_data_ff;

   // Response register stage.
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_data_ff;

   rsp_item_type core_result;
   logic         req_take;
   logic         advance;

   // The held beat moves on when the response register is empty or is being
   // drained this cycle. Only then does the debouncer state advance, so each
   // sample updates the state exactly once.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);

   // The input register can take a new beat whenever it is empty or its
   // current beat moves on in the same cycle.
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   // Register writes; only the low bits of the data that fit a register count.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_ms   <= INTERVAL_RESET;
         cfg_ff.debounce_mode <= MODE_STABLE;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_INTERVAL: cfg_ff.interval_ms   <= csr_wdata[INTERVAL_W-1:0];
            CSR_MODE:     cfg_ff.debounce_mode <= csr_wdata[MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Debouncer state and the per-sample decision logic.
   tid_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .upd_en (advance),
      .item   (in_data_ff),
      .result (core_result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* design/tid_checker.sv */
`include "timed_input_debouncer_top_macros.svh"

module tid_checker
   import tid_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_item_type          rsp_data
);

   logic flags_ok;

   assign flags_ok = (rsp_data.changed == (rsp_data.rose || rsp_data.fell)) &&
                     (!rsp_data.rose || rsp_data.debounced_level) &&
                     (!rsp_data.fell || !rsp_data.debounced_level);

   // A change beat flags exactly one edge, matching the new level.
   `TID_ASSERT_NOW(a_edge_flags, rsp_valid, flags_ok)

   // A change starts the new state, so its current duration is zero.
   `TID_ASSERT_NOW(a_change_restarts, rsp_valid && rsp_data.changed, rsp_data.current_duration == '0)

   // No response can come out in the first cycle after reset.
   `TID_ASSERT_NOW(a_empty_after_reset, $past(reset), !rsp_valid)

   // A stalled response holds until taken.
   `TID_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // With the response register empty, a request is never stalled.
   `TID_ASSERT_NOW(a_req_free, req_valid && !rsp_valid, !req_stall)

endmodule

bind timed_input_debouncer_top tid_checker u_tid_checker (.*);
